FILE: sv/minmod_slope_limiter_core_defines.svh
// Assertion macros used by the limiter RTL.
`ifndef MINMOD_SLOPE_LIMITER_CORE_DEFINES_SVH
`define MINMOD_SLOPE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MMSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MMSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mmsl_pkg.sv
package mmsl_pkg;

   localparam int VAL_W   = 32;  // port width of every value field
   localparam int SLOPE_W = 33;  // difference of two values
   localparam int POS_W   = 18;
   localparam int TOL_W   = 31;
   localparam int CNT_W   = 3;
   localparam int IDX_W   = 2;
   localparam int CSR_A_W = 3;
   localparam int POS_REGS = 4;
   localparam int PROD_W  = SLOPE_W + POS_W;
   localparam int CHK_W   = 36;  // room for 2*own +/- slope - 2*edge

   localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(1);
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);
   localparam logic signed [POS_W-1:0] POS_RESET_0 = -18'sd65536;
   localparam logic signed [POS_W-1:0] POS_RESET_1 = -18'sd29309;
   localparam logic signed [POS_W-1:0] POS_RESET_2 = 18'sd29309;
   localparam logic signed [POS_W-1:0] POS_RESET_3 = 18'sd65536;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_TOLERANCE  = 3'd0,
      CSR_NODE_COUNT = 3'd1,
      CSR_NODE_POS_0 = 3'd2,
      CSR_NODE_POS_1 = 3'd3,
      CSR_NODE_POS_2 = 3'd4,
      CSR_NODE_POS_3 = 3'd5
   } csr_addr_type;

   // Limited slope with the values the edge test needs.
   typedef struct packed {
      logic                       valid;
      logic signed [SLOPE_W-1:0]  slope;
      logic signed [VAL_W-1:0]    own_avg;
      logic signed [VAL_W-1:0]    left_edge;
      logic signed [VAL_W-1:0]    right_edge;
   } slope_beat_type;

   // Element ready for node emission.
   typedef struct packed {
      logic                       valid;
      logic                       unchanged;
      logic signed [SLOPE_W-1:0]  slope;
      logic signed [VAL_W-1:0]    own_avg;
   } elem_beat_type;

endpackage

FILE: sv/minmod_slope_limiter_core.sv
// Minmod slope limiter for one solution component of one 1D element.
// Request channel: drive start high with the element's averages, neighbour
// flags and edge values; the beat is taken at a rising edge where busy is low.
// Response channel: rsp_valid marks each beat for exactly one cycle. An
// element that passes the edge test gives one beat with rsp_changed low;
// otherwise it gives one rebuilt value per node in use, rsp_node_index
// counting up, rsp_last on the final beat. The receiver cannot stall.
// Path: the edge that takes a beat loads the input register; the difference,
// minmod, edge test, node sequencer, multiply and round/saturate registers
// follow in order, and the front stages hold while busy is high.
// Throughput: the node sequencer emits one beat a cycle and keeps an element
// until its final beat (its only beat if unchanged); busy rises only while a
// finished element waits for the sequencer, so unchanged elements flow at one
// per cycle.
// Configuration: csr_ready is always high; write only while idle. Index 0
// tolerance, 1 node_count, 2..5 node positions; other indexes are ignored.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults.
module minmod_slope_limiter_core #(
   parameter int MAX_NODES = 4,
   parameter int WORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [mmsl_pkg::VAL_W-1:0]     req_own_avg,
   input  logic signed [mmsl_pkg::VAL_W-1:0]     req_left_avg,
   input  logic                                  req_left_valid,
   input  logic signed [mmsl_pkg::VAL_W-1:0]     req_right_avg,
   input  logic                                  req_right_valid,
   input  logic signed [mmsl_pkg::VAL_W-1:0]     req_left_edge_value,
   input  logic signed [mmsl_pkg::VAL_W-1:0]     req_right_edge_value,
   output logic                                  rsp_valid,
   output logic [mmsl_pkg::IDX_W-1:0]            rsp_node_index,
   output logic signed [mmsl_pkg::VAL_W-1:0]     rsp_node_value,
   output logic                                  rsp_changed,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mmsl_pkg::CSR_A_W-1:0]          csr_index,
   input  logic [mmsl_pkg::VAL_W-1:0]            csr_data
);

   // Values wider than 32 bits are still handled at 32.
   localparam int VAL_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int NODE_LIM = (MAX_NODES < mmsl_pkg::POS_REGS) ? MAX_NODES : mmsl_pkg::POS_REGS;

   logic [mmsl_pkg::TOL_W-1:0]          tolerance_ff;
   logic [mmsl_pkg::CNT_W-1:0]          node_count_ff;
   logic signed [mmsl_pkg::POS_W-1:0]   node_pos_ff [mmsl_pkg::POS_REGS];
   logic [mmsl_pkg::CSR_A_W-1:0]        pos_sel;

   mmsl_pkg::slope_beat_type            slope_beat;
   mmsl_pkg::elem_beat_type             elem_beat;
   logic                                take_ready, advance;
   logic [mmsl_pkg::VAL_W-1:0]          node_value;

   // Register file: every write beat lands at once.
   assign csr_ready = 1'b1;
   assign pos_sel   = csr_index - mmsl_pkg::CSR_A_W'(mmsl_pkg::CSR_NODE_POS_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= mmsl_pkg::TOL_RESET;
         node_count_ff  <= mmsl_pkg::COUNT_RESET;
         node_pos_ff[0] <= mmsl_pkg::POS_RESET_0;
         node_pos_ff[1] <= mmsl_pkg::POS_RESET_1;
         node_pos_ff[2] <= mmsl_pkg::POS_RESET_2;
         node_pos_ff[3] <= mmsl_pkg::POS_RESET_3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            mmsl_pkg::CSR_TOLERANCE: begin
               tolerance_ff <= csr_data[mmsl_pkg::TOL_W-1:0];
            end
            mmsl_pkg::CSR_NODE_COUNT: begin
               node_count_ff <= csr_data[mmsl_pkg::CNT_W-1:0];
            end
            mmsl_pkg::CSR_NODE_POS_0, mmsl_pkg::CSR_NODE_POS_1,
            mmsl_pkg::CSR_NODE_POS_2, mmsl_pkg::CSR_NODE_POS_3: begin
               node_pos_ff[pos_sel[1:0]] <= csr_data[mmsl_pkg::POS_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Advance the whole front pipeline unless a finished element waits
   // for the node sequencer; hold the front pipeline in that case.
   assign advance = !elem_beat.valid || take_ready;
   assign busy    = !advance;

   mmsl_slope #(
      .VAL_BITS (VAL_BITS)
   ) u_slope (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .accept           (start),
      .own_avg          (req_own_avg),
      .left_avg         (req_left_avg),
      .left_valid       (req_left_valid),
      .right_avg        (req_right_avg),
      .right_valid      (req_right_valid),
      .left_edge_value  (req_left_edge_value),
      .right_edge_value (req_right_edge_value),
      .slope_out        (slope_beat)
   );

   mmsl_edge_check u_edge_check (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tolerance (tolerance_ff),
      .slope_in  (slope_beat),
      .elem_out  (elem_beat)
   );

   mmsl_node_emit #(
      .VAL_BITS (VAL_BITS),
      .NODE_LIM (NODE_LIM)
   ) u_node_emit (
      .clock          (clock),
      .reset          (reset),
      .elem_in        (elem_beat),
      .node_count     (node_count_ff),
      .node_pos       (node_pos_ff),
      .take_ready     (take_ready),
      .rsp_valid      (rsp_valid),
      .rsp_node_index (rsp_node_index),
      .rsp_node_value (node_value),
      .rsp_changed    (rsp_changed),
      .rsp_last       (rsp_last)
   );

   assign rsp_node_value = $signed(node_value);

endmodule

FILE: sv/mmsl_slope.sv
module mmsl_slope #(
   parameter int VAL_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic                                     accept,
   input  logic signed [mmsl_pkg::VAL_W-1:0]        own_avg,
   input  logic signed [mmsl_pkg::VAL_W-1:0]        left_avg,
   input  logic                                     left_valid,
   input  logic signed [mmsl_pkg::VAL_W-1:0]        right_avg,
   input  logic                                     right_valid,
   input  logic signed [mmsl_pkg::VAL_W-1:0]        left_edge_value,
   input  logic signed [mmsl_pkg::VAL_W-1:0]        right_edge_value,
   output mmsl_pkg::slope_beat_type                 slope_out
);

   localparam int SH = mmsl_pkg::VAL_W - VAL_BITS;
   localparam int SW = mmsl_pkg::SLOPE_W;

   // Input stage
   logic                                a_valid_ff;
   logic signed [mmsl_pkg::VAL_W-1:0]   a_own_ff, a_lavg_ff, a_ravg_ff, a_ul_ff, a_ur_ff;
   logic                                a_lval_ff, a_rval_ff;

   // Candidate stage
   logic                                b_valid_ff;
   logic signed [SW-1:0]                b_c0_ff, b_c1_ff, b_c2_ff;
   logic                                b_p1_ff, b_p2_ff;
   logic signed [mmsl_pkg::VAL_W-1:0]   b_own_ff, b_ul_ff, b_ur_ff;

   // Slope stage
   mmsl_pkg::slope_beat_type            c_ff;

   logic signed [mmsl_pkg::VAL_W-1:0]   t_own, t_lavg, t_ravg, t_ul, t_ur;
   logic [SW-1:0]                       m0, m1, m2, best01, best;
   logic                                pos0, kill;
   logic signed [SW-1:0]                slope_in;

   // Reduce each value to the active word width by sign extension.
   always_comb begin
      t_own  = (own_avg <<< SH) >>> SH;
      t_lavg = (left_avg <<< SH) >>> SH;
      t_ravg = (right_avg <<< SH) >>> SH;
      t_ul   = (left_edge_value <<< SH) >>> SH;
      t_ur   = (right_edge_value <<< SH) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_ff.valid <= b_valid_ff;
      end

      if (advance) begin
         a_own_ff  <= t_own;
         a_lavg_ff <= t_lavg;
         a_ravg_ff <= t_ravg;
         a_ul_ff   <= t_ul;
         a_ur_ff   <= t_ur;
         a_lval_ff <= left_valid;
         a_rval_ff <= right_valid;

         b_c0_ff  <= SW'(a_ur_ff) - SW'(a_ul_ff);
         b_c1_ff  <= SW'(a_ravg_ff) - SW'(a_own_ff);
         b_c2_ff  <= SW'(a_own_ff) - SW'(a_lavg_ff);
         b_p1_ff  <= a_rval_ff;
         b_p2_ff  <= a_lval_ff;
         b_own_ff <= a_own_ff;
         b_ul_ff  <= a_ul_ff;
         b_ur_ff  <= a_ur_ff;

         c_ff.slope      <= slope_in;
         c_ff.own_avg    <= b_own_ff;
         c_ff.left_edge  <= b_ul_ff;
         c_ff.right_edge <= b_ur_ff;
      end
   end

   // Minmod: zero on any zero or sign mismatch, else smallest magnitude.
   always_comb begin
      m0   = b_c0_ff[SW-1] ? -b_c0_ff : b_c0_ff;
      m1   = b_c1_ff[SW-1] ? -b_c1_ff : b_c1_ff;
      m2   = b_c2_ff[SW-1] ? -b_c2_ff : b_c2_ff;
      pos0 = !b_c0_ff[SW-1];
      kill = (b_c0_ff == '0)
          || (b_p1_ff && ((b_c1_ff == '0) || (b_c1_ff[SW-1] == pos0)))
          || (b_p2_ff && ((b_c2_ff == '0) || (b_c2_ff[SW-1] == pos0)));
      best01 = (b_p1_ff && (m1 < m0)) ? m1 : m0;
      best   = (b_p2_ff && (m2 < best01)) ? m2 : best01;
      if (kill) begin
         slope_in = '0;
      end else if (pos0) begin
         slope_in = $signed(best);
      end else begin
         slope_in = -$signed(best);
      end
   end

   assign slope_out = c_ff;

endmodule

FILE: sv/mmsl_edge_check.sv
module mmsl_edge_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [mmsl_pkg::TOL_W-1:0]        tolerance,
   input  mmsl_pkg::slope_beat_type          slope_in,
   output mmsl_pkg::elem_beat_type           elem_out
);

   localparam int CW = mmsl_pkg::CHK_W;

   mmsl_pkg::elem_beat_type   d_ff;
   logic signed [CW-1:0]      own2, dl, dr;
   logic [CW-1:0]             mag_l, mag_r, tol2;
   logic                      unchanged_in;

   // Rebuilt edges against the given ones, all in doubled units.
   always_comb begin
      own2  = CW'(slope_in.own_avg) <<< 1;
      dl    = own2 - CW'(slope_in.slope) - (CW'(slope_in.left_edge) <<< 1);
      dr    = own2 + CW'(slope_in.slope) - (CW'(slope_in.right_edge) <<< 1);
      mag_l = dl[CW-1] ? -dl : dl;
      mag_r = dr[CW-1] ? -dr : dr;
      tol2  = {{(CW - mmsl_pkg::TOL_W - 1){1'b0}}, tolerance, 1'b0};
      unchanged_in = (mag_l < tol2) && (mag_r < tol2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (advance) begin
         d_ff.valid <= slope_in.valid;
      end

      if (advance) begin
         d_ff.unchanged <= unchanged_in;
         d_ff.slope     <= slope_in.slope;
         d_ff.own_avg   <= slope_in.own_avg;
      end
   end

   assign elem_out = d_ff;

endmodule

FILE: sv/mmsl_node_emit.sv
`include "minmod_slope_limiter_core_defines.svh"

module mmsl_node_emit #(
   parameter int VAL_BITS = 32,
   parameter int NODE_LIM = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mmsl_pkg::elem_beat_type                  elem_in,
   input  logic [mmsl_pkg::CNT_W-1:0]               node_count,
   input  logic signed [mmsl_pkg::POS_W-1:0]        node_pos [mmsl_pkg::POS_REGS],
   output logic                                     take_ready,
   output logic                                     rsp_valid,
   output logic [mmsl_pkg::IDX_W-1:0]               rsp_node_index,
   output logic [mmsl_pkg::VAL_W-1:0]               rsp_node_value,
   output logic                                     rsp_changed,
   output logic                                     rsp_last
);

   localparam int SW = mmsl_pkg::SLOPE_W;
   localparam int PW = mmsl_pkg::PROD_W;
   localparam int QW = PW - 17;
   localparam int SUMW = QW + 2;
   localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (VAL_BITS - 1)) - 64'sd1);
   localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);
   localparam logic [mmsl_pkg::VAL_W-1:0] VAL_MASK =
      mmsl_pkg::VAL_W'((64'd1 << VAL_BITS) - 64'd1);

   // Node sequencer
   logic                                e_busy_ff;
   logic                                e_unch_ff;
   logic signed [SW-1:0]                e_slope_ff;
   logic signed [mmsl_pkg::VAL_W-1:0]   e_own_ff;
   logic [mmsl_pkg::CNT_W-1:0]          e_cnt_ff;
   logic [mmsl_pkg::IDX_W-1:0]          e_idx_ff;
   logic                                e_last, take;
   logic [mmsl_pkg::CNT_W-1:0]          cnt_in;

   // Product stage
   logic                                p_valid_ff;
   logic signed [PW-1:0]                p_prod_ff;
   logic signed [mmsl_pkg::VAL_W-1:0]   p_own_ff;
   logic [mmsl_pkg::IDX_W-1:0]          p_idx_ff;
   logic                                p_changed_ff, p_last_ff;

   // Result register
   logic                                r_valid_ff;
   logic [mmsl_pkg::IDX_W-1:0]          r_idx_ff;
   logic [mmsl_pkg::VAL_W-1:0]          r_value_ff;
   logic                                r_changed_ff, r_last_ff;

   logic signed [PW:0]                  rounded;
   logic signed [QW-1:0]                q;
   logic signed [SUMW-1:0]              sum, sat;
   logic [mmsl_pkg::VAL_W-1:0]          value_in;

   assign e_last = e_unch_ff
      || (({1'b0, e_idx_ff} + mmsl_pkg::CNT_W'(1)) == e_cnt_ff);
   assign take_ready = !e_busy_ff || e_last;
   assign take = elem_in.valid && take_ready;

   // Clamp the node count to the positions on hand; a count of zero becomes one.
   always_comb begin
      if (node_count == '0) begin
         cnt_in = mmsl_pkg::CNT_W'(1);
      end else if (node_count > mmsl_pkg::CNT_W'(NODE_LIM)) begin
         cnt_in = mmsl_pkg::CNT_W'(NODE_LIM);
      end else begin
         cnt_in = node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_busy_ff  <= 1'b0;
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            e_busy_ff <= 1'b1;
         end else if (e_last) begin
            e_busy_ff <= 1'b0;
         end
         p_valid_ff <= e_busy_ff;
         r_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         e_unch_ff  <= elem_in.unchanged;
         e_slope_ff <= elem_in.slope;
         e_own_ff   <= elem_in.own_avg;
         e_cnt_ff   <= cnt_in;
         e_idx_ff   <= '0;
      end else if (e_busy_ff) begin
         e_idx_ff <= e_idx_ff + mmsl_pkg::IDX_W'(1);
      end

      p_prod_ff    <= e_slope_ff * node_pos[e_idx_ff];
      p_own_ff     <= e_own_ff;
      p_idx_ff     <= e_idx_ff;
      p_changed_ff <= !e_unch_ff;
      p_last_ff    <= e_last;

      r_idx_ff     <= p_changed_ff ? p_idx_ff : '0;
      r_value_ff   <= p_changed_ff ? value_in : '0;
      r_changed_ff <= p_changed_ff;
      r_last_ff    <= p_last_ff;
   end

   // Round half up on the 2^-17 scale, add the average, saturate.
   always_comb begin
      rounded  = (PW + 1)'(p_prod_ff) + (PW + 1)'(65536);
      q        = QW'(rounded >>> 17);
      sum      = SUMW'(p_own_ff) + SUMW'(q);
      if (sum > SAT_HI) begin
         sat = SAT_HI;
      end else if (sum < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = sum;
      end
      value_in = mmsl_pkg::VAL_W'(sat) & VAL_MASK;
   end

   assign rsp_valid      = r_valid_ff;
   assign rsp_node_index = r_idx_ff;
   assign rsp_node_value = r_value_ff;
   assign rsp_changed    = r_changed_ff;
   assign rsp_last       = r_last_ff;

   `MMSL_ASSERT_NOW(a_unchanged_single, clock, reset, rsp_valid && !rsp_changed, rsp_last && (rsp_node_index == '0) && (rsp_node_value == '0), "unchanged element must give a single zero beat")
   `MMSL_ASSERT_NEXT(a_nodes_back_to_back, clock, reset, rsp_valid && !rsp_last, rsp_valid && rsp_changed && (rsp_node_index == $past(rsp_node_index) + mmsl_pkg::IDX_W'(1)), "node beats must follow without gaps in index order")
   `MMSL_ASSERT_NOW(a_count_in_range, clock, reset, e_busy_ff, (e_cnt_ff != '0) && (e_cnt_ff <= mmsl_pkg::CNT_W'(NODE_LIM)), "node count outside the clamped range")

endmodule
